@@ hdl/ipv4_route_cache_forwarder_unit_macros.svh @@
// Assertion macros for the IPv4 route cache forwarder.
// Included by the top level; no other dependencies.
`ifndef IPV4_ROUTE_CACHE_FORWARDER_UNIT_MACROS_SVH
`define IPV4_ROUTE_CACHE_FORWARDER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define RCF_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Next-cycle implication.
`define RCF_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define RCF_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define RCF_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

@@ hdl/rcf_pkg.sv @@
// Types and constants of the IPv4 route cache forwarder.
// No dependencies; used by the top level and the testbench.
`timescale 1ns / 1ps
package rcf_pkg;
   localparam int CACHE_SLOTS   = 4096;
   localparam int ROUTE_ENTRIES = 64;
   localparam int SLOT_W = (CACHE_SLOTS > 1) ? $clog2(CACHE_SLOTS) : 1;
   localparam int RIDX_W = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1;
   localparam int CSR_ADDR_W = 3;

   localparam logic [15:0] ETH_IPV4      = 16'h0800;
   localparam logic [15:0] TTL_CSUM_STEP = 16'h0100;
   localparam logic [5:0]  MAX_PLEN      = 6'd32;

   // Request kinds.
   localparam logic REQ_PACKET = 1'b0;
   localparam logic REQ_ROUTE  = 1'b1;

   // Register indexes.
   localparam logic [CSR_ADDR_W-3:0] CSR_CACHE_ENABLE = '0;

   typedef enum logic [2:0] {
      ACT_PASS_NONIP   = 3'd0,
      ACT_PASS_NOROUTE = 3'd1,
      ACT_PASS_TTL     = 3'd2,
      ACT_REDIRECT     = 3'd3,
      ACT_WRITTEN      = 3'd4
   } action_type;

   typedef enum logic [2:0] {
      ST_CLEAR, ST_IDLE, ST_LOOKUP, ST_CHECK, ST_SCAN, ST_DRAIN, ST_FILL, ST_DONE
   } state_type;

   // One route table word.
   typedef struct packed {
      logic [31:0] prefix;
      logic [5:0]  length;
      logic [7:0]  port;
      logic [47:0] dmac;
      logic [47:0] smac;
   } route_type;

   // Mask of the leading len bits.
   function automatic logic [31:0] prefix_mask(input logic [5:0] len);
      logic [31:0] m;
      if (len == 6'd0) begin
         m = '0;
      end else begin
         m = 32'hFFFF_FFFF << (6'd32 - len);
      end
      return m;
   endfunction
endpackage

@@ hdl/rcf_ifs.sv @@
// Handshake channel interfaces of the IPv4 route cache forwarder.
// No dependencies.
`timescale 1ns / 1ps
interface rcf_req_if;
   logic        valid;
   logic        ready;
   logic        req_type;
   logic        frame_ok;
   logic [15:0] ethertype;
   logic [31:0] dst_ip;
   logic [7:0]  ttl_in;
   logic [15:0] checksum_in;
   logic [5:0]  route_index;
   logic [5:0]  prefix_len;
   logic [7:0]  route_port;
   logic [47:0] route_dmac;
   logic [47:0] route_smac;
   logic        route_valid;
   modport source (output valid, req_type, frame_ok, ethertype, dst_ip, ttl_in,
                   checksum_in, route_index, prefix_len, route_port, route_dmac,
                   route_smac, route_valid, input ready);
   modport sink (input valid, req_type, frame_ok, ethertype, dst_ip, ttl_in,
                 checksum_in, route_index, prefix_len, route_port, route_dmac,
                 route_smac, route_valid, output ready);
endinterface

interface rcf_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  action;
   logic        cache_hit;
   logic [7:0]  out_port;
   logic [7:0]  ttl_out;
   logic [15:0] checksum_out;
   logic [47:0] new_dmac;
   logic [47:0] new_smac;
   modport source (output valid, action, cache_hit, out_port, ttl_out, checksum_out,
                   new_dmac, new_smac, input ready);
   modport sink (input valid, action, cache_hit, out_port, ttl_out, checksum_out,
                 new_dmac, new_smac, output ready);
endinterface

@@ hdl/ipv4_route_cache_forwarder_unit.sv @@
// Top level of the IPv4 route cache forwarder: sequencer, cache and route table.
// Depends on rcf_pkg, rcf_ifs and ipv4_route_cache_forwarder_unit_macros.svh.
`timescale 1ns / 1ps
`include "ipv4_route_cache_forwarder_unit_macros.svh"
// After reset the block sweeps the cache, one slot a cycle, over its CACHE_SLOTS
// (4096) slots; it takes no transaction meanwhile, though register writes are
// taken. It then handles one transaction at a time. A route write or a non-IPv4
// frame goes straight to done; a hit passes lookup and check, a miss then scan,
// drain and fill, and a lookup with the cache off scan, drain and fill alone. The
// scan uses the single compare unit, visiting one route entry per cycle through the
// route memory read port. A result waits in the output register until taken; a
// finished transaction holds in its last cycle while an earlier result still waits.
module ipv4_route_cache_forwarder_unit (
   input  logic                              clock,
   input  logic                              reset,
   rcf_req_if.sink                           req_chan,
   rcf_rsp_if.source                         rsp_chan,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [rcf_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [31:0]                       csr_pwdata,
   output logic [31:0]                       csr_prdata,
   output logic                              csr_pready
);
   rcf_pkg::state_type state_ff, state_in;

   // Latched transaction.
   logic        type_ff, nonip_ff;
   logic [31:0] dst_ff;
   logic [7:0]  ttl_ff;
   logic [15:0] chk_ff;

   // Control and counters.
   logic                      enable_ff;
   logic [rcf_pkg::SLOT_W-1:0] clr_ff;
   logic [rcf_pkg::RIDX_W-1:0] idx_ff, rd_idx_ff;
   logic                      pend_ff;
   logic [rcf_pkg::ROUTE_ENTRIES-1:0] valid_ff;

   // Decision so far.
   logic        found_ff, hit_ff;
   logic [5:0]  best_len_ff;
   logic [7:0]  port_ff;
   logic [47:0] dmac_ff, smac_ff;

   // Memories and their read registers.
   logic [39:0] ctag_mem [rcf_pkg::CACHE_SLOTS];
   logic [95:0] cmac_mem [rcf_pkg::CACHE_SLOTS];
   rcf_pkg::route_type route_mem [rcf_pkg::ROUTE_ENTRIES];
   logic [39:0] ctag_rd_ff;
   logic [95:0] cmac_rd_ff;
   rcf_pkg::route_type route_rd_ff;

   // Output register.
   logic        rsp_valid_ff;
   rcf_pkg::action_type act_ff;
   logic        rsp_hit_ff;
   logic [7:0]  rsp_port_ff, rsp_ttl_ff;
   logic [15:0] rsp_chk_ff;
   logic [47:0] rsp_dmac_ff, rsp_smac_ff;

   // Sequencer outputs.
   logic req_ready, accept, slot_hit, scan_last, load_rsp, match, better;
   logic [rcf_pkg::SLOT_W-1:0] slot;
   rcf_pkg::action_type act_in;
   logic [16:0] csum_sum;
   logic [15:0] csum_fold;

   assign accept   = req_chan.valid && req_ready;
   assign slot     = dst_ff[rcf_pkg::SLOT_W-1:0];
   assign slot_hit = (ctag_rd_ff[39:8] == dst_ff) && (ctag_rd_ff[7:0] != 8'd0);
   assign scan_last = (32'(idx_ff) == rcf_pkg::ROUTE_ENTRIES - 1);

   // Shared compare unit: one route entry a cycle.
   assign match = pend_ff && valid_ff[rd_idx_ff] &&
      (((dst_ff ^ route_rd_ff.prefix) & rcf_pkg::prefix_mask(route_rd_ff.length)) == 32'd0);
   assign better = match && (!found_ff || (route_rd_ff.length > best_len_ff));

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rcf_pkg::ST_CLEAR: begin
            if (32'(clr_ff) == rcf_pkg::CACHE_SLOTS - 1) state_in = rcf_pkg::ST_IDLE;
         end
         rcf_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_chan.req_type == rcf_pkg::REQ_ROUTE || !req_chan.frame_ok ||
                   req_chan.ethertype != rcf_pkg::ETH_IPV4) begin
                  state_in = rcf_pkg::ST_DONE;
               end else if (enable_ff) begin
                  state_in = rcf_pkg::ST_LOOKUP;
               end else begin
                  state_in = rcf_pkg::ST_SCAN;
               end
            end
         end
         rcf_pkg::ST_LOOKUP: state_in = rcf_pkg::ST_CHECK;
         rcf_pkg::ST_CHECK: state_in = slot_hit ? rcf_pkg::ST_DONE : rcf_pkg::ST_SCAN;
         rcf_pkg::ST_SCAN: begin
            if (scan_last) state_in = rcf_pkg::ST_DRAIN;
         end
         rcf_pkg::ST_DRAIN: state_in = rcf_pkg::ST_FILL;
         rcf_pkg::ST_FILL: state_in = rcf_pkg::ST_DONE;
         rcf_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) state_in = rcf_pkg::ST_IDLE;
         end
         default: state_in = rcf_pkg::ST_IDLE;
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      req_ready = 1'b0;
      load_rsp  = 1'b0;
      unique case (state_ff)
         rcf_pkg::ST_IDLE: req_ready = 1'b1;
         rcf_pkg::ST_DONE: load_rsp = !rsp_valid_ff || rsp_chan.ready;
         default: begin
         end
      endcase
   end

   // Result of the finished transaction.
   always_comb begin
      csum_sum  = {1'b0, ~chk_ff} + {1'b0, rcf_pkg::TTL_CSUM_STEP};
      csum_fold = csum_sum[15:0] + 16'(csum_sum[16]);
      if (type_ff == rcf_pkg::REQ_ROUTE) begin
         act_in = rcf_pkg::ACT_WRITTEN;
      end else if (nonip_ff) begin
         act_in = rcf_pkg::ACT_PASS_NONIP;
      end else if (!found_ff) begin
         act_in = rcf_pkg::ACT_PASS_NOROUTE;
      end else if (ttl_ff <= 8'd1) begin
         act_in = rcf_pkg::ACT_PASS_TTL;
      end else begin
         act_in = rcf_pkg::ACT_REDIRECT;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rcf_pkg::ST_CLEAR;
         clr_ff       <= '0;
         enable_ff    <= 1'b0;
         valid_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == rcf_pkg::ST_CLEAR) clr_ff <= clr_ff + 1'b1;
         if (csr_psel && csr_penable && csr_pwrite &&
             csr_paddr[rcf_pkg::CSR_ADDR_W-1:2] == rcf_pkg::CSR_CACHE_ENABLE) begin
            enable_ff <= csr_pwdata[0];
         end
         if (accept && req_chan.req_type == rcf_pkg::REQ_ROUTE &&
             32'(req_chan.route_index) < rcf_pkg::ROUTE_ENTRIES) begin
            valid_ff[rcf_pkg::RIDX_W'(req_chan.route_index)] <= req_chan.route_valid;
         end
         pend_ff <= (state_ff == rcf_pkg::ST_SCAN);
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Transaction and decision registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         type_ff  <= req_chan.req_type;
         nonip_ff <= !req_chan.frame_ok || req_chan.ethertype != rcf_pkg::ETH_IPV4;
         dst_ff   <= req_chan.dst_ip;
         ttl_ff   <= req_chan.ttl_in;
         chk_ff   <= req_chan.checksum_in;
         found_ff <= 1'b0;
         hit_ff   <= 1'b0;
         idx_ff   <= '0;
      end
      if (state_ff == rcf_pkg::ST_CHECK && slot_hit) begin
         found_ff <= 1'b1;
         hit_ff   <= 1'b1;
         port_ff  <= ctag_rd_ff[7:0];
         dmac_ff  <= cmac_rd_ff[95:48];
         smac_ff  <= cmac_rd_ff[47:0];
      end
      if (state_ff == rcf_pkg::ST_SCAN) begin
         idx_ff    <= idx_ff + 1'b1;
         rd_idx_ff <= idx_ff;
      end
      if (better) begin
         found_ff    <= 1'b1;
         best_len_ff <= route_rd_ff.length;
         port_ff     <= route_rd_ff.port;
         dmac_ff     <= route_rd_ff.dmac;
         smac_ff     <= route_rd_ff.smac;
      end
   end

   // Cache tag and port memory.
   always_ff @(posedge clock) begin
      if (state_ff == rcf_pkg::ST_CLEAR) begin
         ctag_mem[clr_ff] <= '0;
      end else if (state_ff == rcf_pkg::ST_FILL && found_ff && enable_ff) begin
         ctag_mem[slot] <= {dst_ff, port_ff};
      end
      if (state_ff == rcf_pkg::ST_LOOKUP) ctag_rd_ff <= ctag_mem[slot];
   end

   // Cache MAC memory.
   always_ff @(posedge clock) begin
      if (state_ff == rcf_pkg::ST_FILL && found_ff && enable_ff) begin
         cmac_mem[slot] <= {dmac_ff, smac_ff};
      end
      if (state_ff == rcf_pkg::ST_LOOKUP) cmac_rd_ff <= cmac_mem[slot];
   end

   // Route table memory.
   always_ff @(posedge clock) begin
      if (accept && req_chan.req_type == rcf_pkg::REQ_ROUTE &&
          32'(req_chan.route_index) < rcf_pkg::ROUTE_ENTRIES) begin
         route_mem[rcf_pkg::RIDX_W'(req_chan.route_index)] <= '{
            prefix: req_chan.dst_ip,
            length: (req_chan.prefix_len > rcf_pkg::MAX_PLEN) ?
                    rcf_pkg::MAX_PLEN : req_chan.prefix_len,
            port:   req_chan.route_port,
            dmac:   req_chan.route_dmac,
            smac:   req_chan.route_smac};
      end
      if (state_ff == rcf_pkg::ST_SCAN) route_rd_ff <= route_mem[idx_ff];
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (load_rsp) begin
         act_ff      <= act_in;
         rsp_hit_ff  <= (act_in == rcf_pkg::ACT_PASS_TTL ||
                         act_in == rcf_pkg::ACT_REDIRECT) ? hit_ff : 1'b0;
         if (act_in == rcf_pkg::ACT_REDIRECT) begin
            rsp_port_ff <= port_ff;
            rsp_ttl_ff  <= ttl_ff - 8'd1;
            rsp_chk_ff  <= ~csum_fold;
            rsp_dmac_ff <= dmac_ff;
            rsp_smac_ff <= smac_ff;
         end else begin
            rsp_port_ff <= '0;
            rsp_ttl_ff  <= '0;
            rsp_chk_ff  <= '0;
            rsp_dmac_ff <= '0;
            rsp_smac_ff <= '0;
         end
      end
   end

   // Port drive.
   assign req_chan.ready        = req_ready;
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.action       = act_ff;
   assign rsp_chan.cache_hit    = rsp_hit_ff;
   assign rsp_chan.out_port     = rsp_port_ff;
   assign rsp_chan.ttl_out      = rsp_ttl_ff;
   assign rsp_chan.checksum_out = rsp_chk_ff;
   assign rsp_chan.new_dmac     = rsp_dmac_ff;
   assign rsp_chan.new_smac     = rsp_smac_ff;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[rcf_pkg::CSR_ADDR_W-1:2] == rcf_pkg::CSR_CACHE_ENABLE) ?
                       {31'd0, enable_ff} : 32'd0;

   // Checks.
   `RCF_ASSERT_IMP(a_no_take_in_clear, clock, reset,
      state_ff == rcf_pkg::ST_CLEAR, !req_chan.ready)
   `RCF_ASSERT_NXT(a_busy_after_take, clock, reset, accept, state_ff != rcf_pkg::ST_IDLE)
   `RCF_ASSERT_IMP(a_rsp_from_done, clock, reset,
      $rose(rsp_valid_ff), $past(state_ff) == rcf_pkg::ST_DONE)
   `RCF_ASSERT_IMP(a_compare_in_scan, clock, reset, pend_ff,
      $past(state_ff) == rcf_pkg::ST_SCAN)
endmodule

@@ tb/tb_ipv4_route_cache_forwarder_unit.sv @@
// Self-checking testbench of the IPv4 route cache forwarder: random and directed
// transactions, a predictor of the cache and route table, and a response scoreboard.
// Depends on rcf_pkg, rcf_ifs and the ipv4_route_cache_forwarder_unit top level.
`timescale 1ns / 1ps

// One request transaction as driven on the input channel.
typedef struct {
   logic        req_type;
   logic        frame_ok;
   logic [15:0] ethertype;
   logic [31:0] dst_ip;
   logic [7:0]  ttl_in;
   logic [15:0] checksum_in;
   logic [5:0]  route_index;
   logic [5:0]  prefix_len;
   logic [7:0]  route_port;
   logic [47:0] route_dmac;
   logic [47:0] route_smac;
   logic        route_valid;
} fwd_request_type;

// One forwarding decision as seen on the response channel.
typedef struct {
   rcf_pkg::action_type action;
   logic                cache_hit;
   logic [7:0]          out_port;
   logic [7:0]          ttl_out;
   logic [15:0]         checksum_out;
   logic [47:0]         new_dmac;
   logic [47:0]         new_smac;
} fwd_decision_type;

// Keeps a private copy of the cache and route table and checks decisions in order.
class forward_scoreboard;
   logic [31:0]   slot_tag   [rcf_pkg::CACHE_SLOTS];
   logic [7:0]    slot_port  [rcf_pkg::CACHE_SLOTS];
   logic [47:0]   slot_dmac  [rcf_pkg::CACHE_SLOTS];
   logic [47:0]   slot_smac  [rcf_pkg::CACHE_SLOTS];
   logic [31:0]   rt_prefix  [rcf_pkg::ROUTE_ENTRIES];
   logic [5:0]    rt_length  [rcf_pkg::ROUTE_ENTRIES];
   logic [7:0]    rt_port    [rcf_pkg::ROUTE_ENTRIES];
   logic [47:0]   rt_dmac    [rcf_pkg::ROUTE_ENTRIES];
   logic [47:0]   rt_smac    [rcf_pkg::ROUTE_ENTRIES];
   logic          rt_valid   [rcf_pkg::ROUTE_ENTRIES];
   logic          cache_on;
   fwd_decision_type pending_decisions[$];
   int            errors;

   function new();
      foreach (slot_tag[i]) begin
         slot_tag[i]  = '0;
         slot_port[i] = '0;
         slot_dmac[i] = '0;
         slot_smac[i] = '0;
      end
      foreach (rt_valid[i]) begin
         rt_valid[i]  = 1'b0;
         rt_prefix[i] = '0;
         rt_length[i] = '0;
         rt_port[i]   = '0;
         rt_dmac[i]   = '0;
         rt_smac[i]   = '0;
      end
      cache_on = 1'b0;
      errors   = 0;
   endfunction

   // Header checksum after the TTL decrement, one's-complement with one fold.
   function logic [15:0] ttl_dec_checksum(logic [15:0] check);
      logic [16:0] sum;
      sum = {1'b0, ~check} + {1'b0, rcf_pkg::TTL_CSUM_STEP};
      sum = {1'b0, sum[15:0]} + {16'd0, sum[16]};
      return ~sum[15:0];
   endfunction

   // Works out the decision for one request and updates the tables.
   function fwd_decision_type predict_forward(fwd_request_type rq);
      fwd_decision_type d;
      logic [rcf_pkg::SLOT_W-1:0] slot;
      logic        found;
      logic [5:0]  best_len;
      int          best;
      logic [31:0] m;
      d = '{rcf_pkg::ACT_PASS_NONIP, 1'b0, '0, '0, '0, '0, '0};
      found = 1'b0;
      best_len = '0;
      best = 0;
      if (rq.req_type == rcf_pkg::REQ_ROUTE) begin
         rt_prefix[rq.route_index] = rq.dst_ip;
         rt_length[rq.route_index] = (rq.prefix_len > 6'd32) ? 6'd32 : rq.prefix_len;
         rt_port[rq.route_index]   = rq.route_port;
         rt_dmac[rq.route_index]   = rq.route_dmac;
         rt_smac[rq.route_index]   = rq.route_smac;
         rt_valid[rq.route_index]  = rq.route_valid;
         d.action = rcf_pkg::ACT_WRITTEN;
         return d;
      end
      if (!rq.frame_ok || rq.ethertype != rcf_pkg::ETH_IPV4) return d;
      slot = rq.dst_ip[rcf_pkg::SLOT_W-1:0];
      if (cache_on && slot_tag[slot] == rq.dst_ip && slot_port[slot] != 8'd0) begin
         d.out_port  = slot_port[slot];
         d.new_dmac  = slot_dmac[slot];
         d.new_smac  = slot_smac[slot];
         d.cache_hit = 1'b1;
         found = 1'b1;
      end else begin
         // Longest prefix wins; the lowest index wins among equal lengths.
         for (int i = 0; i < rcf_pkg::ROUTE_ENTRIES; i++) begin
            if (!rt_valid[i]) continue;
            m = (rt_length[i] == 6'd0) ? 32'd0 : (32'hFFFF_FFFF << (6'd32 - rt_length[i]));
            if (((rq.dst_ip ^ rt_prefix[i]) & m) != 32'd0) continue;
            if (!found || rt_length[i] > best_len) begin
               found = 1'b1;
               best = i;
               best_len = rt_length[i];
            end
         end
         if (found) begin
            d.out_port = rt_port[best];
            d.new_dmac = rt_dmac[best];
            d.new_smac = rt_smac[best];
            if (cache_on) begin
               slot_tag[slot]  = rq.dst_ip;
               slot_port[slot] = d.out_port;
               slot_dmac[slot] = d.new_dmac;
               slot_smac[slot] = d.new_smac;
            end
         end
      end
      if (!found) begin
         d = '{rcf_pkg::ACT_PASS_NOROUTE, 1'b0, '0, '0, '0, '0, '0};
      end else if (rq.ttl_in <= 8'd1) begin
         d = '{rcf_pkg::ACT_PASS_TTL, d.cache_hit, '0, '0, '0, '0, '0};
      end else begin
         d.action = rcf_pkg::ACT_REDIRECT;
         d.ttl_out = rq.ttl_in - 8'd1;
         d.checksum_out = ttl_dec_checksum(rq.checksum_in);
      end
      return d;
   endfunction

   function void note_request(fwd_request_type rq);
      pending_decisions.push_back(predict_forward(rq));
   endfunction

   function void compare_field(string name, logic [47:0] expv, logic [47:0] actv);
      if (expv !== actv) begin
         errors++;
         $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, expv, actv);
      end
   endfunction

   function void check_response(fwd_decision_type got);
      fwd_decision_type e;
      if (pending_decisions.size() == 0) begin
         errors++;
         $display("%0t: unexpected response: expected none, actual action %0d",
                  $time, got.action);
         return;
      end
      e = pending_decisions.pop_front();
      compare_field("action", e.action, got.action);
      compare_field("cache_hit", e.cache_hit, got.cache_hit);
      compare_field("out_port", e.out_port, got.out_port);
      compare_field("ttl_out", e.ttl_out, got.ttl_out);
      compare_field("checksum_out", e.checksum_out, got.checksum_out);
      compare_field("new_dmac", e.new_dmac, got.new_dmac);
      compare_field("new_smac", e.new_smac, got.new_smac);
   endfunction
endclass

module tb_ipv4_route_cache_forwarder_unit;
   localparam int WATCHDOG_LIMIT = 20000;

   logic        clock;
   logic        reset;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [rcf_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   rcf_req_if req_bus ();
   rcf_rsp_if rsp_bus ();

   forward_scoreboard route_sb;
   logic [31:0] dst_pool[32];
   int          idle_cycles;
   int          rsp_stall;
   logic        stall_free;

   ipv4_route_cache_forwarder_unit dut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_bus),
      .rsp_chan(rsp_bus),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   // Clock generation.
   always #10 clock = ~clock;

   // Draws a random pause, with long runs of no pause at all.
   function automatic int draw_gap(logic quiet);
      if (quiet) return 0;
      return $urandom_range(0, 12);
   endfunction

   // Response side: after each taken transaction the sink stalls a random time.
   always @(posedge clock) begin : rsp_side
      int gap;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         rsp_stall <= 0;
      end else if (rsp_bus.valid && rsp_bus.ready) begin
         route_sb.check_response(fwd_decision_type'{
            rcf_pkg::action_type'(rsp_bus.action), rsp_bus.cache_hit,
            rsp_bus.out_port, rsp_bus.ttl_out, rsp_bus.checksum_out,
            rsp_bus.new_dmac, rsp_bus.new_smac});
         gap = draw_gap(stall_free);
         rsp_stall <= (gap > 0) ? gap - 1 : 0;
         rsp_bus.ready <= (gap == 0);
      end else if (rsp_stall > 0) begin
         rsp_stall <= rsp_stall - 1;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // Watchdog: ends the run when nothing has been accepted for too long.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
          || (csr_psel && csr_penable)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_ipv4_route_cache_forwarder_unit failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Drives one request after a random gap and waits until it is taken.
   task automatic send_request(fwd_request_type rq, logic quiet);
      int gap;
      gap = draw_gap(quiet);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.req_type    <= rq.req_type;
      req_bus.frame_ok    <= rq.frame_ok;
      req_bus.ethertype   <= rq.ethertype;
      req_bus.dst_ip      <= rq.dst_ip;
      req_bus.ttl_in      <= rq.ttl_in;
      req_bus.checksum_in <= rq.checksum_in;
      req_bus.route_index <= rq.route_index;
      req_bus.prefix_len  <= rq.prefix_len;
      req_bus.route_port  <= rq.route_port;
      req_bus.route_dmac  <= rq.route_dmac;
      req_bus.route_smac  <= rq.route_smac;
      req_bus.route_valid <= rq.route_valid;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      route_sb.note_request(rq);
   endtask

   // Lowers valid and waits until every expected decision has come back.
   task automatic drain_responses();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (route_sb.pending_decisions.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   // Register write: setup cycle, then access cycle.
   task automatic write_cache_enable(logic value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {rcf_pkg::CSR_CACHE_ENABLE, 2'b00};
      csr_pwdata  <= {31'd0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      route_sb.cache_on = value;
   endtask

   function automatic fwd_request_type route_write(int idx, logic [31:0] pfx, logic [5:0] len,
                                                   logic [7:0] port, logic valid);
      fwd_request_type rq;
      rq = '{rcf_pkg::REQ_ROUTE, 1'($urandom_range(0, 1)), 16'($urandom), pfx, 8'($urandom),
             16'($urandom), 6'(idx), len, port,
             {16'($urandom), 32'($urandom)}, {16'($urandom), 32'($urandom)}, valid};
      return rq;
   endfunction

   function automatic fwd_request_type packet(logic [31:0] dst, logic [7:0] ttl,
                                              logic [15:0] check);
      fwd_request_type rq;
      rq = '{rcf_pkg::REQ_PACKET, 1'b1, rcf_pkg::ETH_IPV4, dst, ttl, check, 6'($urandom),
             6'($urandom), 8'($urandom), {16'($urandom), 32'($urandom)},
             {16'($urandom), 32'($urandom)}, 1'($urandom_range(0, 1))};
      return rq;
   endfunction

   // Random transaction: mostly packets toward installed prefixes, some route
   // updates and some frames that are short or not IPv4.
   function automatic fwd_request_type random_request();
      fwd_request_type rq;
      int pick;
      logic [31:0] dst;
      logic [5:0] len;
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
         len = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(33, 63))
                                           : 6'($urandom_range(0, 32));
         rq = route_write($urandom_range(0, rcf_pkg::ROUTE_ENTRIES - 1),
                          dst_pool[$urandom_range(0, 31)], len,
                          ($urandom_range(0, 7) == 0) ? 8'd0 : 8'($urandom),
                          $urandom_range(0, 9) != 0);
         return rq;
      end
      if (pick < 60) begin
         dst = dst_pool[$urandom_range(0, 31)];
      end else if (pick < 85) begin
         dst = dst_pool[$urandom_range(0, 31)] ^ ($urandom >> $urandom_range(0, 31));
      end else begin
         dst = $urandom;
      end
      rq = packet(dst, ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 1)) : 8'($urandom),
                  16'($urandom));
      if (pick >= 95) begin
         rq.frame_ok = 1'($urandom_range(0, 1));
         rq.ethertype = ($urandom_range(0, 1) == 0) ? rcf_pkg::ETH_IPV4 : 16'($urandom);
      end
      return rq;
   endfunction

   task automatic run_random(int count);
      logic quiet;
      for (int n = 0; n < count; n++) begin
         // Stretches of back-to-back traffic alternate with random pauses.
         if (n % 50 == 0) begin
            quiet = ($urandom_range(0, 3) == 0);
            stall_free = quiet;
         end
         send_request(random_request(), quiet);
      end
   endtask

   // Directed checks of the corner cases, with the cache enabled.
   task automatic run_directed();
      send_request(packet(32'h0A01_0203, 8'd64, 16'h1234), 1'b0);
      send_request(route_write(0, 32'hFFFF_FFFF, 6'd0, 8'd5, 1'b1), 1'b0);
      send_request(route_write(1, 32'h0A00_0000, 6'd8, 8'd10, 1'b1), 1'b0);
      send_request(route_write(2, 32'h0AFF_0000, 6'd8, 8'd11, 1'b1), 1'b0);
      send_request(route_write(3, 32'h0A01_0203, 6'd45, 8'd12, 1'b1), 1'b0);
      send_request(route_write(5, 32'hC0A8_0100, 6'd24, 8'd0, 1'b1), 1'b0);
      send_request(route_write(63, 32'hFFFF_FFFF, 6'd32, 8'hFF, 1'b1), 1'b0);
      send_request(packet(32'h0A01_0203, 8'd255, 16'h0000), 1'b0);
      send_request(packet(32'h0A01_0203, 8'd2, 16'hFFFF), 1'b0);
      send_request(packet(32'h0A01_0203, 8'd1, 16'hFEFF), 1'b0);
      send_request(packet(32'h0A09_0000, 8'd0, 16'h00FF), 1'b0);
      send_request(packet(32'h0A09_0000, 8'd9, 16'h8000), 1'b0);
      send_request(packet(32'hC0A8_0107, 8'd30, 16'h5555), 1'b0);
      send_request(packet(32'hC0A8_0107, 8'd30, 16'hAAAA), 1'b0);
      send_request(packet(32'hFFFF_FFFF, 8'd128, 16'hFFFF), 1'b0);
      send_request(packet(32'h0000_0000, 8'd3, 16'h0001), 1'b0);
      send_request(route_write(3, 32'h0A01_0203, 6'd32, 8'd12, 1'b0), 1'b0);
      send_request(packet(32'h0A01_0203, 8'd7, 16'h1111), 1'b0);
      send_request(route_write(0, 32'h0, 6'd0, 8'd5, 1'b0), 1'b0);
      send_request(packet(32'h1234_5678, 8'd7, 16'h2222), 1'b0);
      begin
         fwd_request_type rq;
         rq = packet(32'h0A01_0203, 8'd64, 16'h1234);
         rq.frame_ok = 1'b0;
         send_request(rq, 1'b0);
         rq.frame_ok = 1'b1;
         rq.ethertype = 16'h86DD;
         send_request(rq, 1'b0);
         rq.ethertype = 16'hFFFF;
         send_request(rq, 1'b0);
      end
   endtask

   initial begin
      route_sb = new();
      clock = 1'b0;
      reset = 1'b1;
      stall_free = 1'b0;
      idle_cycles = 0;
      rsp_stall = 0;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= '0;
      csr_pwdata <= '0;
      req_bus.valid <= 1'b0;
      req_bus.req_type <= rcf_pkg::REQ_PACKET;
      req_bus.frame_ok <= 1'b0;
      req_bus.ethertype <= '0;
      req_bus.dst_ip <= '0;
      req_bus.ttl_in <= '0;
      req_bus.checksum_in <= '0;
      req_bus.route_index <= '0;
      req_bus.prefix_len <= '0;
      req_bus.route_port <= '0;
      req_bus.route_dmac <= '0;
      req_bus.route_smac <= '0;
      req_bus.route_valid <= 1'b0;
      foreach (dst_pool[i]) dst_pool[i] = $urandom;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Cache off from reset.
      run_random(300);
      drain_responses();
      write_cache_enable(1'b1);
      run_directed();
      run_random(600);
      drain_responses();
      write_cache_enable(1'b0);
      run_random(300);
      drain_responses();
      write_cache_enable(1'b1);
      run_random(650);
      drain_responses();

      if (route_sb.errors == 0) begin
         $display("tb_ipv4_route_cache_forwarder_unit passed");
      end else begin
         $display("tb_ipv4_route_cache_forwarder_unit failed");
      end
      $finish;
   end
endmodule
